### rtl/hsl_to_rgb_converter_assert.svh
// Assertion macros used by the checker file of the HSL to RGB converter.
// Every check is sampled on the rising edge of clk and is switched off while rst is high.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

`define HRC_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hsl_to_rgb_converter check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define HRC_CHECK_LATER(lbl, ante, dly, cons) \
  `HRC_CHECK(lbl, (ante) |-> ##dly (cons))

`endif

### rtl/hrc_pkg.sv
package hrc_pkg;

  localparam int HUE_BITS     = 16;
  localparam int CHANNEL_BITS = 8;
  localparam int WIDE_BITS    = 2 * CHANNEL_BITS;
  localparam int FINE_BITS    = WIDE_BITS + HUE_BITS;
  localparam int QUOT_BITS    = CHANNEL_BITS + 1;
  localparam int LANES        = 3;
  localparam int LANE_HI      = 0;
  localparam int LANE_LO      = 1;
  localparam int LANE_MID     = 2;
  localparam int PIPE_LATENCY = 7;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

  // Hue sextants, named by the color at their start and end.
  typedef enum logic [2:0] {
    SEXT_RY = 3'd0,
    SEXT_YG = 3'd1,
    SEXT_GC = 3'd2,
    SEXT_CB = 3'd3,
    SEXT_BM = 3'd4,
    SEXT_MR = 3'd5
  } sext_t;

  typedef logic [WIDE_BITS-1:0] wide_t;
  typedef logic [QUOT_BITS-1:0] quot_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic  valid;
    sext_t sext;
  } ctl_t;

endpackage

### rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter, one pixel per beat.
// Input: a beat is taken at each rising edge where start is high and busy is
// low; hsl carries hue (fraction of a turn), saturation and lightness.
// busy is always low, so a new pixel may be offered in every cycle.
// Output: done is high for exactly one cycle while rgb holds the result; the
// result is taken at the edge that ends that cycle and cannot be held off.
// Throughput is one pixel per clock: a seven-stage pipeline (sextant and
// product, top and bottom values, span multiply, middle channel, two stages
// of divide by the channel maximum, routing and inversion).
// Configuration: cfg_write with cfg_wdata sets the invert flag, which turns
// each channel c into its maximum minus c. Write it only while no pixel is
// in flight.
// Reset (rst, synchronous) clears every stage valid bit and the invert flag;
// pixels in flight at reset are dropped.
module hsl_to_rgb_converter (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  hrc_pkg::hsl_t hsl,
  input  logic          cfg_write,
  input  logic          cfg_wdata,
  output logic          done,
  output hrc_pkg::rgb_t rgb
);
  import hrc_pkg::*;

  logic                    invert_output;
  logic                    accept;
  ctl_t                    ctl2;
  ctl_t                    ctl4;
  ctl_t                    ctl6;
  wide_t                   top2;
  wide_t                   bot2;
  logic [HUE_BITS-1:0]     frac2;
  wide_t                   top4;
  wide_t                   bot4;
  wide_t                   mid4;
  wide_t  [LANES-1:0]      num4;
  quot_t  [LANES-1:0]      quot6;
  quot_t                   red_q;
  quot_t                   green_q;
  quot_t                   blue_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_output <= 1'b0;
    end else if (cfg_write) begin
      invert_output <= cfg_wdata;
    end
  end

  hrc_span u_span (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .hsl      (hsl),
    .ctl      (ctl2),
    .top      (top2),
    .bot      (bot2),
    .frac     (frac2)
  );

  hrc_mid u_mid (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl2),
    .top_in  (top2),
    .bot_in  (bot2),
    .frac_in (frac2),
    .ctl_out (ctl4),
    .top_out (top4),
    .bot_out (bot4),
    .mid_out (mid4)
  );

  always_comb begin
    num4[LANE_HI]  = top4;
    num4[LANE_LO]  = bot4;
    num4[LANE_MID] = mid4;
  end

  hrc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl4),
    .num     (num4),
    .ctl_out (ctl6),
    .quot    (quot6)
  );

  always_comb begin
    case (ctl6.sext)
      SEXT_RY: begin
        red_q = quot6[LANE_HI];  green_q = quot6[LANE_MID]; blue_q = quot6[LANE_LO];
      end
      SEXT_YG: begin
        red_q = quot6[LANE_MID]; green_q = quot6[LANE_HI];  blue_q = quot6[LANE_LO];
      end
      SEXT_GC: begin
        red_q = quot6[LANE_LO];  green_q = quot6[LANE_HI];  blue_q = quot6[LANE_MID];
      end
      SEXT_CB: begin
        red_q = quot6[LANE_LO];  green_q = quot6[LANE_MID]; blue_q = quot6[LANE_HI];
      end
      SEXT_BM: begin
        red_q = quot6[LANE_MID]; green_q = quot6[LANE_LO];  blue_q = quot6[LANE_HI];
      end
      default: begin
        red_q = quot6[LANE_HI];  green_q = quot6[LANE_LO];  blue_q = quot6[LANE_MID];
      end
    endcase
  end

  function automatic logic [CHANNEL_BITS-1:0] finish(quot_t q, logic inv);
    logic [CHANNEL_BITS-1:0] c;
    c = (q > QUOT_BITS'(CH_MAX)) ? CH_MAX : q[CHANNEL_BITS-1:0];
    return inv ? (CH_MAX - c) : c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl6.valid;
    end
    rgb.red   <= finish(red_q, invert_output);
    rgb.green <= finish(green_q, invert_output);
    rgb.blue  <= finish(blue_q, invert_output);
  end

endmodule

### rtl/hrc_span.sv
module hrc_span (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  hrc_pkg::hsl_t                 hsl,
  output hrc_pkg::ctl_t                 ctl,
  output hrc_pkg::wide_t                top,
  output hrc_pkg::wide_t                bot,
  output logic [hrc_pkg::HUE_BITS-1:0]  frac
);
  import hrc_pkg::*;

  logic [HUE_BITS+2:0]     hue6;
  ctl_t                    ctl1;
  wide_t                   prod1;
  logic [CHANNEL_BITS-1:0] light1;
  logic [CHANNEL_BITS-1:0] sat1;
  logic [HUE_BITS-1:0]     frac1;
  logic [WIDE_BITS:0]      light255;
  logic [WIDE_BITS:0]      sat255;
  logic [WIDE_BITS:0]      top_sum;
  logic [WIDE_BITS:0]      bot_diff;
  logic                    light_low;

  // Hue times six: the integer part is the sextant, the rest the fraction within it.
  assign hue6 = {1'b0, hsl.hue, 2'b00} + {2'b00, hsl.hue, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= in_valid;
    end
    ctl1.sext <= sext_t'(hue6[HUE_BITS+2:HUE_BITS]);
    frac1     <= hue6[HUE_BITS-1:0];
    prod1     <= WIDE_BITS'(hsl.lightness) * WIDE_BITS'(hsl.saturation);
    light1    <= hsl.lightness;
    sat1      <= hsl.saturation;
  end

  // Top and bottom values are kept in units of one over CH_MAX squared.
  always_comb begin
    light255  = {1'b0, light1, {CHANNEL_BITS{1'b0}}} - {{(CHANNEL_BITS+1){1'b0}}, light1};
    sat255    = {1'b0, sat1, {CHANNEL_BITS{1'b0}}} - {{(CHANNEL_BITS+1){1'b0}}, sat1};
    light_low = ({light1, 1'b0} <= {1'b0, CH_MAX});
    if (light_low) begin
      top_sum = light255 + {1'b0, prod1};
    end else begin
      top_sum = light255 + sat255 - {1'b0, prod1};
    end
    bot_diff = {light255[WIDE_BITS-1:0], 1'b0} - top_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl1.valid;
    end
    ctl.sext <= ctl1.sext;
    top      <= top_sum[WIDE_BITS-1:0];
    bot      <= bot_diff[WIDE_BITS-1:0];
    frac     <= frac1;
  end

endmodule

### rtl/hrc_mid.sv
module hrc_mid (
  input  logic                          clk,
  input  logic                          rst,
  input  hrc_pkg::ctl_t                 ctl_in,
  input  hrc_pkg::wide_t                top_in,
  input  hrc_pkg::wide_t                bot_in,
  input  logic [hrc_pkg::HUE_BITS-1:0]  frac_in,
  output hrc_pkg::ctl_t                 ctl_out,
  output hrc_pkg::wide_t                top_out,
  output hrc_pkg::wide_t                bot_out,
  output hrc_pkg::wide_t                mid_out
);
  import hrc_pkg::*;

  wide_t                span;
  ctl_t                 ctl3;
  wide_t                top3;
  wide_t                bot3;
  logic [FINE_BITS-1:0] prod3;
  logic [FINE_BITS-1:0] fine_val;

  assign span = top_in - bot_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else begin
      ctl3.valid <= ctl_in.valid;
    end
    ctl3.sext <= ctl_in.sext;
    top3      <= top_in;
    bot3      <= bot_in;
    prod3     <= FINE_BITS'(span) * FINE_BITS'(frac_in);
  end

  // Odd sextants fall from the top value, even ones rise from the bottom value.
  always_comb begin
    if (ctl3.sext[0]) begin
      fine_val = {top3, {HUE_BITS{1'b0}}} - prod3;
    end else begin
      fine_val = {bot3, {HUE_BITS{1'b0}}} + prod3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl3.valid;
    end
    ctl_out.sext <= ctl3.sext;
    top_out      <= top3;
    bot_out      <= bot3;
    mid_out      <= fine_val[FINE_BITS-1:HUE_BITS];
  end

endmodule

### rtl/hrc_div.sv
module hrc_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hrc_pkg::ctl_t                         ctl_in,
  input  hrc_pkg::wide_t [hrc_pkg::LANES-1:0]   num,
  output hrc_pkg::ctl_t                         ctl_out,
  output hrc_pkg::quot_t [hrc_pkg::LANES-1:0]   quot
);
  import hrc_pkg::*;

  localparam int SCALED_BITS = 3 * CHANNEL_BITS + 1;

  logic [SCALED_BITS-1:0]  scaled [LANES];
  ctl_t                    ctl5;
  wide_t  [LANES-1:0]      num5;
  quot_t  [LANES-1:0]      est5;
  logic [WIDE_BITS:0]      back [LANES];
  logic [WIDE_BITS:0]      rem [LANES];

  // Multiplying by 2^CHANNEL_BITS + 1 and dropping the low bits underestimates
  // the quotient by CH_MAX by at most one, which the second stage corrects.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      scaled[i] = {1'b0, num[i], {CHANNEL_BITS{1'b0}}} + SCALED_BITS'(num[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5.valid <= 1'b0;
    end else begin
      ctl5.valid <= ctl_in.valid;
    end
    ctl5.sext <= ctl_in.sext;
    for (int i = 0; i < LANES; i++) begin
      num5[i] <= num[i];
      est5[i] <= scaled[i][SCALED_BITS-1:WIDE_BITS];
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      back[i] = {est5[i], {CHANNEL_BITS{1'b0}}} - (WIDE_BITS+1)'(est5[i]);
      rem[i]  = {1'b0, num5[i]} - back[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl5.valid;
    end
    ctl_out.sext <= ctl5.sext;
    for (int i = 0; i < LANES; i++) begin
      quot[i] <= est5[i] + QUOT_BITS'(rem[i] >= (WIDE_BITS+1)'(CH_MAX));
    end
  end

endmodule

### rtl/hrc_checker.sv
`include "hsl_to_rgb_converter_assert.svh"

module hrc_assert_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input hrc_pkg::hsl_t hsl,
  input logic          done,
  input hrc_pkg::rgb_t rgb
);
  import hrc_pkg::*;

  logic gray_beat;
  logic gray_out;

  assign gray_beat = start && !busy && (hsl.lightness == '0 || hsl.saturation == '0);
  assign gray_out  = (rgb.red == rgb.green) && (rgb.green == rgb.blue);

  `HRC_CHECK(a_never_busy, !busy)

  // Every input beat comes out after the fixed pipeline latency.
  `HRC_CHECK_LATER(a_done_follows_beat, start && !busy, PIPE_LATENCY, done)

  // No result appears without an input beat the same latency earlier.
  `HRC_CHECK(a_done_has_beat, done |-> $past(start && !busy, PIPE_LATENCY))

  // Black or gray input yields three equal channels, inverted or not.
  `HRC_CHECK_LATER(a_gray_stays_gray, gray_beat, PIPE_LATENCY, gray_out)

endmodule

bind hsl_to_rgb_converter hrc_assert_checker u_hrc_checker (.*);

### tb/hrc_checker.sv
// Watches the pixel and result channels of the HSL to RGB converter, predicts
// each result from the accepted pixel and the current invert flag, and
// compares the results in order.
module hrc_checker
  import hrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  busy,
  input  hsl_t  hsl,
  input  logic  cfg_write,
  input  logic  cfg_wdata,
  input  logic  done,
  input  rgb_t  rgb,
  output int    mismatch_count,
  output int    checked_count,
  output int    pending_count
);

  localparam longint unsigned CMAX = (64'd1 << CHANNEL_BITS) - 1;

  rgb_t rgb_expected_q[$];
  bit   invert_flag;

  initial begin
    mismatch_count = 0;
    checked_count  = 0;
    pending_count  = 0;
    invert_flag    = 1'b0;
  end

  function automatic logic [CHANNEL_BITS-1:0] fold_channel(longint unsigned c, bit inv);
    longint unsigned v;
    v = (c > CMAX) ? CMAX : c;
    if (inv) begin
      v = CMAX - v;
    end
    return v[CHANNEL_BITS-1:0];
  endfunction

  // Exact integer version of the HSL formulas. Top and bottom values are kept
  // in units of 1/M^2 so every division by M truncates like the block does.
  function automatic rgb_t predict_rgb(hsl_t px, bit inv);
    longint unsigned l, s, h, top_v, bot_v, span, h6, frac;
    longint unsigned hi, lo, mid, r, g, b;
    logic [2:0]      sext_bits;
    sext_t           sext;
    rgb_t            res;
    l = 64'(px.lightness);
    s = 64'(px.saturation);
    h = 64'(px.hue);
    if (2 * l <= CMAX) begin
      top_v = l * (CMAX + s);
    end else begin
      top_v = l * CMAX + s * CMAX - l * s;
    end
    bot_v = 2 * l * CMAX - top_v;
    span  = top_v - bot_v;
    h6        = h * 6;
    sext_bits = 3'(h6 >> HUE_BITS);
    sext      = sext_t'(sext_bits);
    frac      = h6 % (64'd1 << HUE_BITS);
    hi = top_v / CMAX;
    lo = bot_v / CMAX;
    // Odd sextants fall from the top value, even ones rise from the bottom.
    if (sext_bits[0]) begin
      mid = (((top_v << HUE_BITS) - span * frac) >> HUE_BITS) / CMAX;
    end else begin
      mid = (((bot_v << HUE_BITS) + span * frac) >> HUE_BITS) / CMAX;
    end
    case (sext)
      SEXT_RY: begin r = hi;  g = mid; b = lo;  end
      SEXT_YG: begin r = mid; g = hi;  b = lo;  end
      SEXT_GC: begin r = lo;  g = hi;  b = mid; end
      SEXT_CB: begin r = lo;  g = mid; b = hi;  end
      SEXT_BM: begin r = mid; g = lo;  b = hi;  end
      default: begin r = hi;  g = lo;  b = mid; end
    endcase
    res.red   = fold_channel(r, inv);
    res.green = fold_channel(g, inv);
    res.blue  = fold_channel(b, inv);
    return res;
  endfunction

  task automatic check_channel(string name, logic [CHANNEL_BITS-1:0] want,
                               logic [CHANNEL_BITS-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      rgb_expected_q.delete();
      invert_flag = 1'b0;
    end else begin
      if (done) begin
        if (rgb_expected_q.size() == 0) begin
          $error("result beat with no pixel outstanding: %h", rgb);
          mismatch_count++;
        end else begin
          want = rgb_expected_q.pop_front();
          check_channel("red", want.red, rgb.red);
          check_channel("green", want.green, rgb.green);
          check_channel("blue", want.blue, rgb.blue);
          checked_count++;
        end
      end
      if (start && !busy) begin
        rgb_expected_q.push_back(predict_rgb(hsl, invert_flag));
      end
      if (cfg_write) begin
        invert_flag = cfg_wdata;
      end
    end
    pending_count = rgb_expected_q.size();
  end

endmodule

### tb/tb_hsl_to_rgb_converter.sv
module tb_hsl_to_rgb_converter;
  import hrc_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  hsl_t hsl;
  logic cfg_write;
  logic cfg_wdata;
  logic done;
  rgb_t rgb;

  int mismatch_count;
  int checked_count;
  int pending_count;
  int sent_count;

  logic [CHANNEL_BITS-1:0] corner_vals [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

  hsl_to_rgb_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .hsl       (hsl),
    .cfg_write (cfg_write),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .rgb       (rgb)
  );

  hrc_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .hsl            (hsl),
    .cfg_write      (cfg_write),
    .cfg_wdata      (cfg_wdata),
    .done           (done),
    .rgb            (rgb),
    .mismatch_count (mismatch_count),
    .checked_count  (checked_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("** hsl_to_rgb_converter: FAILED **");
    $finish;
  end

  function automatic hsl_t pix(logic [HUE_BITS-1:0] h, logic [CHANNEL_BITS-1:0] s,
                               logic [CHANNEL_BITS-1:0] l);
    hsl_t p;
    p.hue        = h;
    p.saturation = s;
    p.lightness  = l;
    return p;
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] pick_channel();
    if ($urandom_range(2) == 0) begin
      return corner_vals[$urandom_range(5)];
    end
    return CHANNEL_BITS'($urandom);
  endfunction

  // Mostly uniform pixels, with extra weight on channel corners and on hues
  // just around the sextant boundaries.
  function automatic hsl_t random_pixel();
    logic [HUE_BITS-1:0] h;
    int                  k;
    k = $urandom_range(5);
    case ($urandom_range(2))
      0: h = HUE_BITS'($urandom);
      1: h = HUE_BITS'(((k * 65536) + 5) / 6 + int'($urandom_range(8)) - 4);
      default: h = HUE_BITS'((k * 65536) / 6 + int'($urandom_range(65536 / 6)));
    endcase
    return pix(h, pick_channel(), pick_channel());
  endfunction

  // Called and returns at a falling edge. start stays high between back to
  // back beats.
  task automatic send_pixel(hsl_t p, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      hsl   = $urandom;
      @(negedge clk);
    end
    start = 1'b1;
    hsl   = p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_invert(bit inv);
    drain();
    cfg_write = 1'b1;
    cfg_wdata = inv;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_wdata = 1'b0;
  endtask

  task automatic run_random(int count, int idle_pct);
    for (int i = 0; i < count; i++) begin
      send_pixel(random_pixel(), idle_pct);
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    hsl        = '0;
    cfg_write  = 1'b0;
    cfg_wdata  = 1'b0;
    sent_count = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    write_invert(1'b0);
    // Sextant starts at full saturation and mid lightness, then interiors.
    send_pixel(pix(16'd0, 8'd255, 8'd128), 0);
    send_pixel(pix(16'd65535, 8'd255, 8'd128), 0);
    send_pixel(pix(16'd10923, 8'd255, 8'd128), 0);
    send_pixel(pix(16'd21845, 8'd255, 8'd128), 0);
    send_pixel(pix(16'd32768, 8'd255, 8'd128), 0);
    send_pixel(pix(16'd43691, 8'd255, 8'd128), 0);
    send_pixel(pix(16'd54613, 8'd255, 8'd128), 0);
    send_pixel(pix(16'd5461, 8'd200, 8'd100), 0);
    send_pixel(pix(16'd16384, 8'd200, 8'd100), 0);
    send_pixel(pix(16'd27307, 8'd200, 8'd100), 0);
    send_pixel(pix(16'd38229, 8'd200, 8'd100), 0);
    send_pixel(pix(16'd49152, 8'd200, 8'd100), 0);
    send_pixel(pix(16'd60075, 8'd200, 8'd100), 0);
    // Zero saturation gives gray, zero lightness gives black.
    send_pixel(pix(16'd12345, 8'd0, 8'd77), 0);
    send_pixel(pix(16'd40000, 8'd255, 8'd0), 0);
    send_pixel(pix(16'd40000, 8'd0, 8'd0), 0);
    send_pixel(pix(16'd0, 8'd0, 8'd255), 0);
    send_pixel(pix(16'd30000, 8'd255, 8'd255), 0);
    // Lightness on either side of one half switches the top value formula.
    send_pixel(pix(16'd20000, 8'd128, 8'd127), 0);
    send_pixel(pix(16'd20000, 8'd128, 8'd128), 0);
    send_pixel(pix(16'd65535, 8'd1, 8'd1), 0);
    send_pixel(pix(16'd1, 8'd254, 8'd254), 0);
    drain();

    write_invert(1'b1);
    send_pixel(pix(16'd0, 8'd255, 8'd128), 0);
    send_pixel(pix(16'd40000, 8'd255, 8'd0), 0);
    run_random(630, 32);
    write_invert(1'b0);
    run_random(630, 58);
    write_invert(1'b1);
    run_random(630, 0);

    drain();
    $display("Sent %0d pixels and checked %0d results over all hue sextants,",
             sent_count, checked_count);
    $display("both output polarities and three input pacing mixes.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("** hsl_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsl_to_rgb_converter: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/hrc_pkg.sv
rtl/hrc_span.sv
rtl/hrc_mid.sv
rtl/hrc_div.sv
rtl/hsl_to_rgb_converter.sv
rtl/hrc_checker.sv
tb/hrc_checker.sv
tb/tb_hsl_to_rgb_converter.sv
